### sv/lteb_pkg.sv
// ----------------------------------------------------------------------------
// lteb_pkg
// Shared types and constants of the line text edit buffer.
// ----------------------------------------------------------------------------
package lteb_pkg;

	localparam logic [1:0] CMD_KEY  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	localparam logic [7:0] KEY_ESC   = 8'd27;
	localparam logic [7:0] KEY_LF    = 8'd10;
	localparam logic [7:0] KEY_CR    = 8'd13;
	localparam logic [7:0] KEY_BS    = 8'd8;
	localparam logic [7:0] KEY_DEL   = 8'd127;
	localparam logic [7:0] KEY_BRKT  = 8'h5B;
	localparam logic [7:0] KEY_UP    = 8'h41;
	localparam logic [7:0] KEY_DOWN  = 8'h42;
	localparam logic [7:0] KEY_RIGHT = 8'h43;
	localparam logic [7:0] KEY_LEFT  = 8'h44;
	localparam logic [7:0] KEY_THREE = 8'h33;
	localparam logic [7:0] KEY_TILDE = 8'h7E;

	localparam logic [1:0] ESC_IDLE  = 2'd0;
	localparam logic [1:0] ESC_SEEN  = 2'd1;
	localparam logic [1:0] ESC_CSI   = 2'd2;
	localparam logic [1:0] ESC_CSI3  = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  key_byte;
		logic [10:0] read_index;
	} cmd_word_t;

	typedef struct packed {
		logic [11:0] cursor_col;
		logic [11:0] cursor_row;
		logic [11:0] text_length;
		logic [7:0]  stored_byte;
		logic        session_ended;
		logic        unknown_sequence;
	} rsp_word_t;

endpackage

### sv/lteb_ram.sv
// ----------------------------------------------------------------------------
// lteb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lteb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/line_text_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_text_edit_buffer
// Keystroke driven text editor core: edits a byte store at a cursor and
// reports cursor row, column and text length for every word taken in.
// ----------------------------------------------------------------------------
//
//  channel   signals               direction  handshake
//  command   start, cmd_word       in         taken when start && !busy
//  response  done, rsp_word        out        one-cycle strobe, no stall
//
// A word is decoded in the cycle it is taken, then any store work runs, then
// a scan of the store up to the cursor counts row and column; the strobe
// follows the last cycle of the scan. A read first issues its RAM read in
// ST_RD and captures the byte in ST_RDW. An insert or delete moves one byte
// per cycle over the text behind the edit point. An up or down move reads
// and tests one byte at a time, in ST_WRD and then ST_WEV; a down move from
// the start of a text with no line feed is the worst item. busy drops in the
// cycle the strobe is high. Reset clears the cursor, length, escape and
// ended state at once; the RAM is not cleared since no position at or
// beyond the length is ever read. The response side cannot stall.
// ----------------------------------------------------------------------------
module line_text_edit_buffer #(
	parameter int STORE_DEPTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lteb_pkg::cmd_word_t cmd_word,
	output logic                done,
	output lteb_pkg::rsp_word_t rsp_word
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = AW + 1;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;  // issue read for a read command
	localparam logic [3:0] ST_RDW  = 4'd2;  // capture the read byte
	localparam logic [3:0] ST_INS  = 4'd3;  // shift tail up, then place byte
	localparam logic [3:0] ST_DEL  = 4'd4;  // shift tail down over a byte
	localparam logic [3:0] ST_WRD  = 4'd5;  // cursor walk: issue read
	localparam logic [3:0] ST_WEV  = 4'd6;  // cursor walk: test for line feed
	localparam logic [3:0] ST_SCI  = 4'd7;  // scan init
	localparam logic [3:0] ST_SCN  = 4'd8;  // row/column scan

	logic [3:0]    state_q;
	logic [PW-1:0] cur_q, len_q, ptr_q, row_q, col_q;
	logic [1:0]    esc_q;
	logic          ended_q, unk_q, up_q, ph_q;
	logic [7:0]    byte_q, stored_q;
	logic          pend_s1;
	logic [AW-1:0] wadr_s1;
	logic          done_q;
	lteb_pkg::rsp_word_t rsp_q;

	// Read index held for the read command; only the low AW bits are used
	// once it has been checked against the length.
	logic [10:0] cmd_word_rd_q;

	// RAM ports.
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          rd_lf;

	lteb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_text_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_lf = (ram_rdata == lteb_pkg::KEY_LF);
	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign rsp_word = rsp_q;

	// Memory port steering: each state owns the ports it uses.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wadr_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(cmd_word_rd_q);
			end
			ST_INS: begin
				if (pend_s1) begin
					ram_we = 1'b1;
				end else if (ptr_q == cur_q) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q[AW-1:0];
					ram_wdata = byte_q;
				end
				if (ptr_q > cur_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(ptr_q - PW'(1));
				end
			end
			ST_DEL: begin
				ram_we = pend_s1;
				if ((ptr_q + PW'(1)) < len_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(ptr_q + PW'(1));
				end
			end
			ST_WRD: begin
				ram_re = (ptr_q < len_q);
			end
			ST_SCN: begin
				ram_re = (ptr_q < cur_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			len_q   <= '0;
			esc_q   <= lteb_pkg::ESC_IDLE;
			ended_q <= 1'b0;
			unk_q   <= 1'b0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unk_q    <= 1'b0;
						stored_q <= '0;
						pend_s1  <= 1'b0;
						cmd_word_rd_q <= cmd_word.read_index;
						state_q  <= ST_SCI;
						if (cmd_word.cmd == lteb_pkg::CMD_READ) begin
							if (32'(cmd_word.read_index) < 32'(len_q)) begin
								state_q <= ST_RD;
							end
						end else if (!ended_q && cmd_word.cmd == lteb_pkg::CMD_TICK) begin
							if (esc_q == lteb_pkg::ESC_SEEN) begin
								ended_q <= 1'b1;
							end
							esc_q <= lteb_pkg::ESC_IDLE;
						end else if (!ended_q && cmd_word.cmd == lteb_pkg::CMD_KEY) begin
							unique case (esc_q)
								lteb_pkg::ESC_SEEN: begin
									esc_q <= (cmd_word.key_byte == lteb_pkg::KEY_BRKT)
										? lteb_pkg::ESC_CSI : lteb_pkg::ESC_IDLE;
								end
								lteb_pkg::ESC_CSI: begin
									esc_q <= lteb_pkg::ESC_IDLE;
									unique case (cmd_word.key_byte)
										lteb_pkg::KEY_UP: begin
											up_q    <= 1'b1;
											ph_q    <= 1'b0;
											ptr_q   <= cur_q;
											state_q <= ST_WRD;
										end
										lteb_pkg::KEY_DOWN: begin
											up_q    <= 1'b0;
											ptr_q   <= cur_q;
											state_q <= ST_WRD;
										end
										lteb_pkg::KEY_RIGHT: begin
											if (cur_q < len_q) cur_q <= cur_q + PW'(1);
										end
										lteb_pkg::KEY_LEFT: begin
											if (cur_q != '0) cur_q <= cur_q - PW'(1);
										end
										lteb_pkg::KEY_THREE: begin
											esc_q <= lteb_pkg::ESC_CSI3;
										end
										default: begin
											unk_q <= 1'b1;
										end
									endcase
								end
								lteb_pkg::ESC_CSI3: begin
									esc_q <= lteb_pkg::ESC_IDLE;
									if (cmd_word.key_byte == lteb_pkg::KEY_TILDE
										&& cur_q < len_q) begin
										ptr_q   <= cur_q;
										state_q <= ST_DEL;
									end
								end
								default: begin
									priority if (cmd_word.key_byte == lteb_pkg::KEY_LF
										|| cmd_word.key_byte == lteb_pkg::KEY_CR) begin
										byte_q <= lteb_pkg::KEY_LF;
										ptr_q  <= len_q;
										if (len_q < PW'(STORE_DEPTH)) state_q <= ST_INS;
									end else if (cmd_word.key_byte == lteb_pkg::KEY_BS
										|| cmd_word.key_byte == lteb_pkg::KEY_DEL) begin
										// Backspace removes the byte before the cursor
										// and moves the cursor onto its place.
										if (len_q != '0 && cur_q != '0) begin
											ptr_q   <= cur_q - PW'(1);
											cur_q   <= cur_q - PW'(1);
											state_q <= ST_DEL;
										end
									end else if (cmd_word.key_byte == lteb_pkg::KEY_ESC) begin
										esc_q <= lteb_pkg::ESC_SEEN;
									end else begin
										byte_q <= cmd_word.key_byte;
										ptr_q  <= len_q;
										if (len_q < PW'(STORE_DEPTH)) state_q <= ST_INS;
									end
								end
							endcase
						end
					end
				end

				ST_RD: begin
					state_q <= ST_RDW;
				end

				ST_RDW: begin
					stored_q <= ram_rdata;
					state_q  <= ST_SCI;
				end

				ST_INS: begin
					// Tail bytes move up one place, highest first; the pending
					// read is written one address above where it was read.
					if (ptr_q > cur_q) begin
						pend_s1 <= 1'b1;
						wadr_s1 <= ptr_q[AW-1:0];
						ptr_q   <= ptr_q - PW'(1);
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						len_q   <= len_q + PW'(1);
						cur_q   <= cur_q + PW'(1);
						state_q <= ST_SCI;
					end
				end

				ST_DEL: begin
					// Tail bytes move down one place, lowest first.
					if ((ptr_q + PW'(1)) < len_q) begin
						pend_s1 <= 1'b1;
						wadr_s1 <= ptr_q[AW-1:0];
						ptr_q   <= ptr_q + PW'(1);
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						len_q   <= len_q - PW'(1);
						state_q <= ST_SCI;
					end
				end

				ST_WRD: begin
					if (up_q) begin
						if (ptr_q == '0) begin
							// Start of text reached: end this leg of the walk.
							if (ph_q) begin
								cur_q   <= '0;
								state_q <= ST_SCI;
							end else begin
								ph_q <= 1'b1;
							end
						end else if (ptr_q >= len_q) begin
							ptr_q <= ptr_q - PW'(1);
						end else begin
							state_q <= ST_WEV;
						end
					end else begin
						if (ptr_q >= len_q) begin
							cur_q   <= ptr_q;
							state_q <= ST_SCI;
						end else begin
							state_q <= ST_WEV;
						end
					end
				end

				ST_WEV: begin
					state_q <= ST_WRD;
					if (up_q) begin
						if (rd_lf) begin
							// Line feed found; ptr_q is nonzero here.
							if (ph_q) begin
								cur_q   <= ptr_q + PW'(1);
								state_q <= ST_SCI;
							end else begin
								ph_q  <= 1'b1;
								ptr_q <= ptr_q - PW'(1);
							end
						end else begin
							ptr_q <= ptr_q - PW'(1);
						end
					end else begin
						if (rd_lf) begin
							cur_q   <= ptr_q + PW'(1);
							state_q <= ST_SCI;
						end else begin
							ptr_q <= ptr_q + PW'(1);
						end
					end
				end

				ST_SCI: begin
					ptr_q   <= '0;
					row_q   <= '0;
					col_q   <= '0;
					pend_s1 <= 1'b0;
					state_q <= ST_SCN;
				end

				ST_SCN: begin
					if (pend_s1) begin
						if (rd_lf) begin
							row_q <= row_q + PW'(1);
							col_q <= '0;
						end else begin
							col_q <= col_q + PW'(1);
						end
					end
					if (ptr_q < cur_q) begin
						pend_s1 <= 1'b1;
						ptr_q   <= ptr_q + PW'(1);
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response register, loaded as the scan completes.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCN && !(ptr_q < cur_q) && !pend_s1) begin
			rsp_q.cursor_col       <= 12'(col_q);
			rsp_q.cursor_row       <= 12'(row_q);
			rsp_q.text_length      <= 12'(len_q);
			rsp_q.stored_byte      <= stored_q;
			rsp_q.session_ended    <= ended_q;
			rsp_q.unknown_sequence <= unk_q;
		end
	end

	// The cursor never passes the end of the text.
	a_cur_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q) else $error("cursor beyond text length");

	// The length never exceeds the store.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= PW'(STORE_DEPTH)) else $error("text length beyond store depth");

	// A response only follows the end of a scan.
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_SCN) else $error("response without scan");

	// The RAM is only written while the text is being edited.
	a_write_in_edit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_INS || state_q == ST_DEL))
		else $error("RAM write outside an edit");

	// An ended session stays ended.
	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> ended_q) else $error("session end flag cleared");

endmodule
